// ----- rtl/ocbb_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the overlapping chunk bounding box block.
// No dependencies; imported by overlapping_chunk_bounding_boxes.
package ocbb_pkg;

    // configuration register indexes
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_LIMIT    = 2'd1;

    // counter widths
    localparam int CNT_BITS = 16;

    // recent vertex history kept for the overlap seed
    localparam int RECENT_DEPTH = 3;

    // chunk size divider: one quotient bit per cycle
    localparam int DIV_STEPS     = CNT_BITS;
    localparam int DIV_STEP_BITS = $clog2(DIV_STEPS + 1);

    // result queue
    localparam int QDEPTH     = 4;
    localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

endpackage

// ----- rtl/overlapping_chunk_bounding_boxes.sv -----
`timescale 1ns / 1ps
// Top level: groups polyline vertices into overlapping chunks and emits their boxes.
// Depends on ocbb_pkg.

// One vertex is taken per clock when the result side keeps up and no division
// runs: the box extent, the seed from the last OVERLAP vertices and the
// end-of-stream test all settle combinationally from the incoming request into
// the state registers and a four-entry result queue. A vertex that closes a
// full chunk and also ends the stream yields two boxes, so the queue drains one
// box per cycle while out_stall is low and in_stall rises while it holds more
// than two. After every write to vertex_count or the box limit a bit-serial
// divider works out the chunk size (vertex_count / (max(box limit,2) - 1), at
// least MIN_CHUNK); in_stall is high while it runs. The chunk size is taken up
// at the first vertex of each stream, so a write to the box limit in the middle
// of a stream applies to the next one, while vertex_count is always compared live.
module overlapping_chunk_bounding_boxes
    import ocbb_pkg::*;
#(
    parameter int OVERLAP    = 3,
    parameter int MIN_CHUNK  = 4,
    parameter int COORD_BITS = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_we,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] box_left,
    output logic signed [COORD_BITS-1:0] box_top,
    output logic [COORD_BITS-1:0]        box_width,
    output logic [COORD_BITS-1:0]        box_height,
    output logic                         final_box
);

    localparam int BOX_BITS = 4 * COORD_BITS + 1;

    // configuration registers
    logic [CNT_BITS-1:0] vertex_count_reg;
    logic [CNT_BITS-1:0] box_limit_reg;

    // chunk size divider
    logic                     div_pend_reg;
    logic                     div_run_reg;
    logic [DIV_STEP_BITS-1:0] div_step_reg;
    logic [CNT_BITS-1:0]      div_rem_reg;
    logic [CNT_BITS-1:0]      div_quo_reg;
    logic [CNT_BITS-1:0]      div_dsr_reg;
    logic [CNT_BITS-1:0]      div_quot_reg;
    logic [CNT_BITS:0]        div_rem_sh;
    logic [CNT_BITS:0]        div_trial;
    logic [CNT_BITS-1:0]      div_quo_next;
    logic [CNT_BITS-1:0]      div_rem_next;
    logic                     div_busy;

    // stream state
    logic signed [COORD_BITS-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic signed [COORD_BITS-1:0] min_x_next, max_x_next, min_y_next, max_y_next;
    logic [CNT_BITS-1:0]          in_box_cnt_reg, in_box_cnt_next;
    logic [CNT_BITS-1:0]          stream_idx_reg, stream_idx_next;
    logic [CNT_BITS-1:0]          chunk_size_reg, chunk_size_next;
    logic signed [COORD_BITS-1:0] recent_x_reg [RECENT_DEPTH];
    logic signed [COORD_BITS-1:0] recent_y_reg [RECENT_DEPTH];

    // per-vertex datapath
    logic                         in_acc;
    logic                         live;
    logic                         first;
    logic                         full;
    logic                         last;
    logic [CNT_BITS-1:0]          chunk_cur;
    logic [CNT_BITS-1:0]          cnt_cur;
    logic [CNT_BITS-1:0]          base_cnt;
    logic signed [COORD_BITS-1:0] seed_min_x, seed_max_x, seed_min_y, seed_max_y;
    logic signed [COORD_BITS-1:0] base_min_x, base_max_x, base_min_y, base_max_y;
    logic [BOX_BITS-1:0]          box_full;
    logic [BOX_BITS-1:0]          box_last;
    logic [BOX_BITS-1:0]          res0;
    logic [1:0]                   n_res;

    // result queue, head at entry 0
    logic [BOX_BITS-1:0]  q_reg [QDEPTH];
    logic [BOX_BITS-1:0]  q_next [QDEPTH];
    logic [QCNT_BITS-1:0] q_cnt_reg, q_cnt_next;
    logic [QCNT_BITS-1:0] q_base;
    logic                 pop;

    // handshakes
    assign div_busy  = div_pend_reg | div_run_reg;
    assign in_stall  = div_busy || (q_cnt_reg > QCNT_BITS'(QDEPTH - 2));
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = (q_cnt_reg != '0);
    assign pop       = out_valid && !out_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= '0;
            box_limit_reg    <= CNT_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VERTEX_COUNT: vertex_count_reg <= cfg_data;
                REG_BOX_LIMIT:    box_limit_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // divider step: restoring, one quotient bit per cycle
    always_comb
    begin
        div_rem_sh   = {div_rem_reg, div_quo_reg[CNT_BITS-1]};
        div_trial    = div_rem_sh - {1'b0, div_dsr_reg};
        div_quo_next = {div_quo_reg[CNT_BITS-2:0], ~div_trial[CNT_BITS]};
        div_rem_next = div_trial[CNT_BITS] ? div_rem_sh[CNT_BITS-1:0]
                                           : div_trial[CNT_BITS-1:0];
    end

    // divider control; a write restarts it with the new register values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_pend_reg <= 1'b0;
            div_run_reg  <= 1'b0;
            div_step_reg <= '0;
            div_quot_reg <= CNT_BITS'(MIN_CHUNK);
        end
        else if (cfg_we && (cfg_index inside {REG_VERTEX_COUNT, REG_BOX_LIMIT}))
        begin
            div_pend_reg <= 1'b1;
            div_run_reg  <= 1'b0;
        end
        else if (div_pend_reg)
        begin
            div_pend_reg <= 1'b0;
            div_run_reg  <= 1'b1;
            div_step_reg <= DIV_STEP_BITS'(DIV_STEPS);
        end
        else if (div_run_reg)
        begin
            div_step_reg <= div_step_reg - DIV_STEP_BITS'(1);
            if (div_step_reg == DIV_STEP_BITS'(1))
            begin
                div_run_reg <= 1'b0;
                if (div_quo_next < CNT_BITS'(MIN_CHUNK))
                    div_quot_reg <= CNT_BITS'(MIN_CHUNK);
                else
                    div_quot_reg <= div_quo_next;
            end
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        if (div_pend_reg)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= vertex_count_reg;
            div_dsr_reg <= (box_limit_reg < CNT_BITS'(2)) ? CNT_BITS'(1)
                                                          : box_limit_reg - CNT_BITS'(1);
        end
        else if (div_run_reg)
        begin
            div_rem_reg <= div_rem_next;
            div_quo_reg <= div_quo_next;
        end
    end

    // vertex datapath: chunk test, overlap seed, extent update, stream end
    always_comb
    begin
        live      = in_acc && (vertex_count_reg != '0);
        first     = (stream_idx_reg == '0);
        chunk_cur = first ? div_quot_reg : chunk_size_reg;
        cnt_cur   = first ? '0 : in_box_cnt_reg;
        full      = (cnt_cur >= chunk_cur);
        last      = ({1'b0, stream_idx_reg} + (CNT_BITS + 1)'(1)) >= {1'b0, vertex_count_reg};

        // extent of the last OVERLAP vertices
        seed_min_x = recent_x_reg[0];
        seed_max_x = recent_x_reg[0];
        seed_min_y = recent_y_reg[0];
        seed_max_y = recent_y_reg[0];
        for (int k = 1; k < OVERLAP; k++)
        begin
            if (recent_x_reg[k] < seed_min_x) seed_min_x = recent_x_reg[k];
            if (recent_x_reg[k] > seed_max_x) seed_max_x = recent_x_reg[k];
            if (recent_y_reg[k] < seed_min_y) seed_min_y = recent_y_reg[k];
            if (recent_y_reg[k] > seed_max_y) seed_max_y = recent_y_reg[k];
        end

        if (full)
        begin
            base_min_x = seed_min_x;
            base_max_x = seed_max_x;
            base_min_y = seed_min_y;
            base_max_y = seed_max_y;
            base_cnt   = CNT_BITS'(OVERLAP);
        end
        else
        begin
            base_min_x = min_x_reg;
            base_max_x = max_x_reg;
            base_min_y = min_y_reg;
            base_max_y = max_y_reg;
            base_cnt   = cnt_cur;
        end

        // add the new vertex
        if (base_cnt == '0)
        begin
            min_x_next = pos_x;
            max_x_next = pos_x;
            min_y_next = pos_y;
            max_y_next = pos_y;
        end
        else
        begin
            min_x_next = (pos_x < base_min_x) ? pos_x : base_min_x;
            max_x_next = (pos_x > base_max_x) ? pos_x : base_max_x;
            min_y_next = (pos_y < base_min_y) ? pos_y : base_min_y;
            max_y_next = (pos_y > base_max_y) ? pos_y : base_max_y;
        end

        in_box_cnt_next = last ? '0 : base_cnt + CNT_BITS'(1);
        stream_idx_next = last ? '0 : stream_idx_reg + CNT_BITS'(1);
        chunk_size_next = chunk_cur;

        // boxes: the closed chunk, then the final one
        box_full = {min_x_reg, min_y_reg, max_x_reg - min_x_reg, max_y_reg - min_y_reg, 1'b0};
        box_last = {min_x_next, min_y_next, max_x_next - min_x_next,
                    max_y_next - min_y_next, 1'b1};
        res0     = full ? box_full : box_last;
        n_res    = live ? ({1'b0, full} + {1'b0, last}) : 2'd0;
    end

    // stream control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_box_cnt_reg <= '0;
            stream_idx_reg <= '0;
            chunk_size_reg <= CNT_BITS'(MIN_CHUNK);
        end
        else if (live)
        begin
            in_box_cnt_reg <= in_box_cnt_next;
            stream_idx_reg <= stream_idx_next;
            chunk_size_reg <= chunk_size_next;
        end
    end

    // extent and vertex history
    always_ff @(posedge clk)
    begin
        if (live)
        begin
            min_x_reg <= min_x_next;
            max_x_reg <= max_x_next;
            min_y_reg <= min_y_next;
            max_y_reg <= max_y_next;
            recent_x_reg[0] <= pos_x;
            recent_y_reg[0] <= pos_y;
            for (int k = 1; k < RECENT_DEPTH; k++)
            begin
                recent_x_reg[k] <= recent_x_reg[k-1];
                recent_y_reg[k] <= recent_y_reg[k-1];
            end
        end
    end

    // result queue: shift on pop, append up to two boxes
    always_comb
    begin
        q_base     = q_cnt_reg - QCNT_BITS'(pop);
        q_cnt_next = q_base + QCNT_BITS'(n_res);
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (pop && (i < QDEPTH - 1))
                q_next[i] = q_reg[(i < QDEPTH - 1) ? i + 1 : i];
            else
                q_next[i] = q_reg[i];
            if ((n_res != 2'd0) && (QCNT_BITS'(i) == q_base))
                q_next[i] = res0;
            if ((n_res == 2'd2) && (QCNT_BITS'(i) == q_base + QCNT_BITS'(1)))
                q_next[i] = box_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_cnt_reg <= '0;
        else
            q_cnt_reg <= q_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
            q_reg[i] <= q_next[i];
    end

    // head of the queue drives the result request
    assign box_left   = q_reg[0][BOX_BITS-1 -: COORD_BITS];
    assign box_top    = q_reg[0][BOX_BITS-1-COORD_BITS -: COORD_BITS];
    assign box_width  = q_reg[0][BOX_BITS-1-2*COORD_BITS -: COORD_BITS];
    assign box_height = q_reg[0][BOX_BITS-1-3*COORD_BITS -: COORD_BITS];
    assign final_box  = q_reg[0][0];

`ifndef SYNTHESIS
    // queue never holds more than its depth
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= QCNT_BITS'(QDEPTH))
        else $error("result queue overflow");

    // a vertex that ends the stream leaves the stream index at zero
    a_stream_end: assert property (@(posedge clk) disable iff (!rst_n)
        (live && last) |=> (stream_idx_reg == '0 && in_box_cnt_reg == '0))
        else $error("stream did not restart after final box");

    // the latched chunk size never drops below the minimum
    a_chunk_min: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_size_reg >= CNT_BITS'(MIN_CHUNK) && div_quot_reg >= CNT_BITS'(MIN_CHUNK))
        else $error("chunk size below minimum");

    // the box being built never exceeds its chunk
    a_box_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (stream_idx_reg != '0) |-> (in_box_cnt_reg <= chunk_size_reg))
        else $error("box holds more vertices than its chunk");

    // no vertex is taken while the chunk size is being worked out
    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        div_run_reg |-> !in_acc)
        else $error("vertex accepted during chunk size division");
`endif

endmodule
